>>> rtl/core/assert_macros.svh
// Assertion helpers, sampled on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/hrk_pkg.sv
package hrk_pkg;

  typedef logic [17:0]        pos_t;      // Q10.8
  typedef logic signed [15:0] energy_t;   // Q4.12
  typedef logic [9:0]         box_t;
  typedef logic [23:0]        recip_t;    // Q8.16
  typedef logic [31:0]        rate_t;     // Q0.32
  typedef logic [2:0]         cfg_idx_t;
  typedef logic [23:0]        cfg_data_t;
  typedef logic signed [18:0] disp_t;     // folded displacement, Q.8

  typedef enum logic [2:0] {
    REG_BOX_X    = 3'd0,
    REG_BOX_Y    = 3'd1,
    REG_BOX_Z    = 3'd2,
    REG_FIELD    = 3'd3,
    REG_TINV_LOC = 3'd4,
    REG_INV_TEMP = 3'd5,
    REG_ZERO_T   = 3'd6
  } cfg_reg_e;

  localparam int SQ_STAGES = 27;   // result bits of the square root
  localparam int EXP_BITS  = 37;   // exponent bits fed to the product chain
  localparam int TAYLOR_N  = 24;

  localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;
  localparam logic [55:0] X_LIMIT = 56'd23 << 32;

  typedef logic [61:0] exp_tab_t [EXP_BITS];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // exp(-2^(i-32)) in Q0.62, evaluated at elaboration
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i <= 32; i++) begin
      t    = 64'd1 << (i + 30);
      term = 64'(ONE_Q62);
      sum  = 64'(ONE_Q62);
      for (int n = 1; n <= TAYLOR_N; n++) begin
        term = mul_q62(term, t) / 64'(n);
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      tab[i] = sum[61:0];
    end
    for (int i = 33; i < EXP_BITS; i++) begin
      sum    = mul_q62(64'(tab[i-1]), 64'(tab[i-1]));
      tab[i] = sum[61:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // single minimum-image fold of to - from
  function automatic disp_t fold_axis(input pos_t from, input pos_t to, input box_t len);
    logic signed [19:0] d;
    logic signed [19:0] half;
    logic signed [19:0] full;
    d    = $signed({2'b00, to}) - $signed({2'b00, from});
    half = $signed({3'b000, len, 7'b0});
    full = $signed({2'b00, len, 8'b0});
    if (d > half) begin
      d = d - full;
    end else if (d < -half) begin
      d = d + full;
    end
    return d[18:0];
  endfunction

endpackage

>>> rtl/core/hopping_rate_kernel.sv
// Channel | Signals                               | Moves
// --------+---------------------------------------+------------------------------
// in      | in_valid, in_ready, from_*, to_*      | one site pair per transfer
// out     | out_valid, out_ready, hop_rate        | one rate per transfer
// cfg     | cfg_valid, cfg_ready, cfg_index/data  | one register write per transfer
//
// One pair enters per cycle while the output register can take data (no stall).
// Depth is set by the 27-stage square root and the 37 two-stage exp multiply steps.
// rst (synchronous) clears valid bits and loads the register defaults; the exp
// table is a constant, so the block takes a pair in the first cycle after reset.
// A stalled output freezes the whole pipe in place: no pair is lost or repeated.
`include "assert_macros.svh"

module hopping_rate_kernel (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hrk_pkg::pos_t      from_x,
  input  hrk_pkg::pos_t      from_y,
  input  hrk_pkg::pos_t      from_z,
  input  hrk_pkg::energy_t   from_energy,
  input  hrk_pkg::pos_t      to_x,
  input  hrk_pkg::pos_t      to_y,
  input  hrk_pkg::pos_t      to_z,
  input  hrk_pkg::energy_t   to_energy,
  output logic               out_valid,
  input  logic               out_ready,
  output hrk_pkg::rate_t     hop_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  hrk_pkg::cfg_idx_t  cfg_index,
  input  hrk_pkg::cfg_data_t cfg_data
);
  import hrk_pkg::*;

  // ---------------------------------------------------------------- config
  box_t           box_x, box_y, box_z;
  energy_t        field;
  recip_t         tinv_loc, inv_temp;
  logic           zero_t;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x    <= 10'd16;
      box_y    <= 10'd16;
      box_z    <= 10'd16;
      field    <= '0;
      tinv_loc <= 24'd131072;
      inv_temp <= 24'd65536;
      zero_t   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_X:    box_x    <= cfg_data[9:0];
        REG_BOX_Y:    box_y    <= cfg_data[9:0];
        REG_BOX_Z:    box_z    <= cfg_data[9:0];
        REG_FIELD:    field    <= cfg_data[15:0];
        REG_TINV_LOC: tinv_loc <= cfg_data;
        REG_INV_TEMP: inv_temp <= cfg_data;
        REG_ZERO_T:   zero_t   <= cfg_data[0];
        default:      ;   // index beyond the list: ignored
      endcase
    end
  end

  // Global advance: every stage moves when the output register can take data.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------- stage 1: fold
  logic               s1_v;
  disp_t              s1_dx, s1_dy, s1_dz;
  logic signed [16:0] s1_ed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx <= fold_axis(from_x, to_x, box_x);
      s1_dy <= fold_axis(from_y, to_y, box_y);
      s1_dz <= fold_axis(from_z, to_z, box_z);
      s1_ed <= 17'(to_energy) - 17'(from_energy);
    end
  end

  // ---------------------------------------------------------------- stage 2: squares, field term
  logic               s2_v;
  logic [35:0]        s2_sqx, s2_sqy, s2_sqz;
  logic signed [34:0] s2_fdz;
  logic signed [16:0] s2_ed;
  logic signed [37:0] sqx_c, sqy_c, sqz_c;
  logic signed [34:0] fdz_c;

  assign sqx_c = 38'(s1_dx) * 38'(s1_dx);
  assign sqy_c = 38'(s1_dy) * 38'(s1_dy);
  assign sqz_c = 38'(s1_dz) * 38'(s1_dz);
  assign fdz_c = 35'(field) * 35'(s1_dz);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sqx <= sqx_c[35:0];
      s2_sqy <= sqy_c[35:0];
      s2_sqz <= sqz_c[35:0];
      s2_fdz <= fdz_c;
      s2_ed  <= s1_ed;
    end
  end

  // ---------------------------------------------------------------- stage 3: sum, dE
  logic [37:0]        sq_c;
  logic signed [35:0] de_c;
  logic               up_c;

  assign sq_c = {2'b00, s2_sqx} + {2'b00, s2_sqy} + {2'b00, s2_sqz};
  assign de_c = $signed({{11{s2_ed[16]}}, s2_ed, 8'b0}) - $signed({s2_fdz[34], s2_fdz});
  assign up_c = !de_c[35] && (de_c != '0);

  // Square root, one result bit per stage; index 0 is loaded by stage 3.
  logic        rt_v    [0:SQ_STAGES];
  logic [31:0] rt_rem  [0:SQ_STAGES];
  logic [26:0] rt_root [0:SQ_STAGES];
  logic [53:0] rt_s    [0:SQ_STAGES];
  logic        rt_up   [0:SQ_STAGES];
  logic [34:0] rt_de   [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_v[0] <= 1'b0;
    end else if (adv) begin
      rt_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
      rt_s[0]    <= {sq_c, 16'b0};
      rt_up[0]   <= up_c;
      rt_de[0]   <= up_c ? de_c[34:0] : '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [31:0] rem_sh;
    logic [31:0] trial;
    assign rem_sh = {rt_rem[k][29:0], rt_s[k][53:52]};
    assign trial  = {3'b000, rt_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[k+1] <= 1'b0;
      end else if (adv) begin
        rt_v[k+1] <= rt_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          rt_rem[k+1]  <= rem_sh - trial;
          rt_root[k+1] <= {rt_root[k][25:0], 1'b1};
        end else begin
          rt_rem[k+1]  <= rem_sh;
          rt_root[k+1] <= {rt_root[k][25:0], 1'b0};
        end
        rt_s[k+1]  <= {rt_s[k][51:0], 2'b00};
        rt_up[k+1] <= rt_up[k];
        rt_de[k+1] <= rt_de[k];
      end
    end
  end

  // ---------------------------------------------------------------- exponent products
  logic        m1_v;
  logic [50:0] m1_xd;
  logic [58:0] m1_xe;
  logic        m1_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= rt_v[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_xd <= 51'(tinv_loc) * 51'(rt_root[SQ_STAGES]);
      m1_xe <= 59'(inv_temp) * 59'(rt_de[SQ_STAGES]);
      m1_up <= rt_up[SQ_STAGES];
    end
  end

  // exponent sum and zero decision; feeds the exp chain
  logic [55:0] x_c;
  assign x_c = 56'(m1_xd) + 56'(m1_xe[58:4]);

  logic        ex_v   [0:EXP_BITS];
  logic [62:0] ex_acc [0:EXP_BITS];
  logic [36:0] ex_x   [0:EXP_BITS];
  logic        ex_z   [0:EXP_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_v[0] <= 1'b0;
    end else if (adv) begin
      ex_v[0] <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_acc[0] <= ONE_Q62;
      ex_x[0]   <= x_c[36:0];
      ex_z[0]   <= (x_c >= X_LIMIT) || (m1_up && zero_t);
    end
  end

  // ---------------------------------------------------------------- exp chain
  // Step i: partial products of acc by table entry i, then sum and take Q62 if exponent bit i is set, else keep acc.
  logic        pa_v   [0:EXP_BITS-1];
  logic [63:0] pa_ll  [0:EXP_BITS-1];
  logic [61:0] pa_lh  [0:EXP_BITS-1];
  logic [62:0] pa_hl  [0:EXP_BITS-1];
  logic [60:0] pa_hh  [0:EXP_BITS-1];
  logic [62:0] pa_acc [0:EXP_BITS-1];
  logic [36:0] pa_x   [0:EXP_BITS-1];
  logic        pa_z   [0:EXP_BITS-1];

  for (genvar i = 0; i < EXP_BITS; i++) begin : g_exp
    logic [124:0] prod;
    assign prod = {61'b0, pa_ll[i]} + {31'b0, pa_lh[i], 32'b0}
                + {30'b0, pa_hl[i], 32'b0} + {pa_hh[i], 64'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        pa_v[i]   <= 1'b0;
        ex_v[i+1] <= 1'b0;
      end else if (adv) begin
        pa_v[i]   <= ex_v[i];
        ex_v[i+1] <= pa_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pa_ll[i]  <= 64'(ex_acc[i][31:0])  * 64'(EXP_TAB[i][31:0]);
        pa_lh[i]  <= 62'(ex_acc[i][31:0])  * 62'(EXP_TAB[i][61:32]);
        pa_hl[i]  <= 63'(ex_acc[i][62:32]) * 63'(EXP_TAB[i][31:0]);
        pa_hh[i]  <= 61'(ex_acc[i][62:32]) * 61'(EXP_TAB[i][61:32]);
        pa_acc[i] <= ex_acc[i];
        pa_x[i]   <= ex_x[i];
        pa_z[i]   <= ex_z[i];

        ex_acc[i+1] <= pa_x[i][i] ? prod[124:62] : pa_acc[i];
        ex_x[i+1]   <= pa_x[i];
        ex_z[i+1]   <= pa_z[i];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic [32:0] rate_c;
  assign rate_c = ex_acc[EXP_BITS][62:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ex_v[EXP_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ex_z[EXP_BITS]) begin
        hop_rate <= '0;
      end else if (rate_c[32]) begin
        hop_rate <= '1;   // saturate just below 1.0
      end else begin
        hop_rate <= rate_c[31:0];
      end
    end
  end

  // ---------------------------------------------------------------- checks
  `ASSERT_IMPL(a_sqrt_rem, rt_v[SQ_STAGES], rt_rem[SQ_STAGES] <= {4'b0000, rt_root[SQ_STAGES], 1'b0}, "sqrt remainder out of range")
  `ASSERT_IMPL(a_acc_bound, ex_v[EXP_BITS], ex_acc[EXP_BITS] <= ONE_Q62, "exp accumulator above one")
  `ASSERT_IMPL(a_out_src, $rose(out_valid), $past(ex_v[EXP_BITS]), "result without a pipe item")
  `ASSERT_NEXT(a_freeze, !in_ready, $stable(s1_v) && $stable(ex_v[EXP_BITS]), "pipe moved while stalled")

endmodule
